// ----- hdl/fixed_capacity_multiset_table_core_defines.svh -----
// ----------------------------------------------------------------------------
// Multiset table assertion macros
// Shared concurrent assertion forms, clocked on i_clk and gated by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef FIXED_CAPACITY_MULTISET_TABLE_CORE_DEFINES_SVH
`define FIXED_CAPACITY_MULTISET_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define FCMT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FCMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/fcmt_pkg.sv -----
// ----------------------------------------------------------------------------
// Multiset table package
// Action codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package fcmt_pkg;

    localparam int ACT_W   = 2;
    localparam int VALUE_W = 32;
    localparam int FIELD_W = 5;
    localparam int OUT_W   = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_COUNT  = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic load;       // latch the incoming word
        logic clr_scan;   // restart scan index, tallies and flags
        logic rd_scan;    // read the entry at the scan index
        logic rd_last;    // read the last held entry
        logic wr_add;     // append the value
        logic wr_move;    // copy last entry into the matched slot
        logic cnt_clear;  // empty the table
        logic res_load;   // load the output register
    } t_dp_cmd;

    typedef struct packed {
        t_action act;
        logic    full;
        logic    scan_end;
        logic    rd_vld;
        logic    hit;
        logic    out_free;
    } t_dp_sts;

endpackage

// ----- hdl/fcmt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Multiset table controller
// Sequences one action at a time: execute, scan, move and result hand-off.
// ----------------------------------------------------------------------------
module fcmt_ctrl import fcmt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    output logic    o_s_ready,
    input  t_action i_act,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.clr_scan = 1'b1;
                    if (i_act == ACT_ADD || i_act == ACT_CLEAR) begin
                        n_state = S_EXEC;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_EXEC: begin
                unique case (i_sts.act)
                    ACT_ADD:   o_cmd.wr_add    = !i_sts.full;
                    ACT_CLEAR: o_cmd.cnt_clear = 1'b1;
                    default:   o_cmd.wr_add    = 1'b0;
                endcase
                n_state = S_RESULT;
            end
            S_SCAN: begin
                // a remove stops at the first match; the last read drains first
                if (i_sts.hit && i_sts.act == ACT_REMOVE) begin
                    n_state = S_MOVE_RD;
                end else if (!i_sts.scan_end) begin
                    o_cmd.rd_scan = 1'b1;
                end else if (!i_sts.rd_vld) begin
                    n_state = S_RESULT;
                end
            end
            S_MOVE_RD: begin
                o_cmd.rd_last = 1'b1;
                n_state       = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                o_cmd.wr_move = 1'b1;
                n_state       = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/fcmt_dp.sv -----
// ----------------------------------------------------------------------------
// Multiset table datapath
// Entry memory, count, scan compare, tallies and the output register.
// ----------------------------------------------------------------------------
`include "fixed_capacity_multiset_table_core_defines.svh"

module fcmt_dp import fcmt_pkg::*; #(
    parameter int CAPACITY   = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_action            i_act,
    input  logic [VALUE_W-1:0] i_value,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    output logic               o_m_valid,
    input  logic               i_m_ready,
    output logic [OUT_W-1:0]   o_m_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [ITEM_WIDTH-1:0] mem [CAPACITY];

    t_action               r_act;
    logic [ITEM_WIDTH-1:0] r_value;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;
    logic                  r_rd_vld;
    logic [AW-1:0]         r_rd_idx;
    logic [ITEM_WIDTH-1:0] r_rd_data;
    logic [CW-1:0]         r_match;
    logic                  r_found;
    logic [AW-1:0]         r_found_idx;
    logic                  r_add_ok;
    logic                  r_out_vld;
    logic [OUT_W-1:0]      r_out_data;

    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         last_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ITEM_WIDTH-1:0] wr_data;
    logic                  hit;
    logic                  full;
    logic                  out_free;
    logic                  success;
    logic [FIELD_W-1:0]    match_field;
    logic [OUT_W-1:0]      n_out_data;

    assign full      = (r_count == CW'(CAPACITY));
    assign hit       = r_rd_vld && (r_rd_data == r_value);
    assign out_free  = !r_out_vld || i_m_ready;
    assign last_addr = AW'(r_count - 1'b1);

    assign rd_en   = i_cmd.rd_scan | i_cmd.rd_last;
    assign rd_addr = i_cmd.rd_last ? last_addr : r_idx[AW-1:0];
    assign wr_en   = i_cmd.wr_add | i_cmd.wr_move;
    assign wr_addr = i_cmd.wr_add ? r_count[AW-1:0] : r_found_idx;
    assign wr_data = i_cmd.wr_add ? r_value : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= i_act;
            r_value <= ITEM_WIDTH'(i_value);
        end
        if (i_cmd.rd_scan) begin
            r_rd_idx <= r_idx[AW-1:0];
        end
        if (hit && !r_found) begin
            r_found_idx <= r_rd_idx;
        end
        if (i_cmd.res_load) begin
            r_out_data <= n_out_data;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_match   <= '0;
            r_found   <= 1'b0;
            r_add_ok  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.cnt_clear) begin
                r_count <= '0;
            end else if (i_cmd.wr_add) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.wr_move) begin
                r_count <= r_count - 1'b1;
            end

            r_rd_vld <= i_cmd.rd_scan;

            if (i_cmd.clr_scan) begin
                r_idx    <= '0;
                r_match  <= '0;
                r_found  <= 1'b0;
                r_add_ok <= 1'b0;
            end else begin
                if (i_cmd.rd_scan) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (hit) begin
                    r_match <= r_match + 1'b1;
                    if (r_act == ACT_REMOVE) begin
                        r_found <= 1'b1;
                    end
                end
                if (i_cmd.wr_add) begin
                    r_add_ok <= 1'b1;
                end
            end

            if (i_cmd.res_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_comb begin
        unique case (r_act)
            ACT_ADD:    success = r_add_ok;
            ACT_REMOVE: success = r_found;
            ACT_COUNT:  success = (r_match != '0);
            ACT_CLEAR:  success = 1'b1;
            default:    success = 1'b0;
        endcase
        match_field = (r_act == ACT_COUNT) ? FIELD_W'(r_match) : '0;
        n_out_data  = '0;
        n_out_data[0]   = success;
        n_out_data[5:1] = match_field;
        n_out_data[10:6] = FIELD_W'(r_count);
        n_out_data[11]  = (r_count == '0);
        n_out_data[12]  = full;
    end

    assign o_sts.act      = r_act;
    assign o_sts.full     = full;
    assign o_sts.scan_end = (r_idx == r_count);
    assign o_sts.rd_vld   = r_rd_vld;
    assign o_sts.hit      = hit;
    assign o_sts.out_free = out_free;

    assign o_m_valid = r_out_vld;
    assign o_m_data  = r_out_data;

    `FCMT_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CW'(CAPACITY), "count above capacity")
    `FCMT_ASSERT_IMPL(a_add_room, i_cmd.wr_add, !full, "add into a full table")
    `FCMT_ASSERT_IMPL(a_move_found, i_cmd.wr_move, r_found && (r_count != '0), "move without match")
    `FCMT_ASSERT_IMPL(a_scan_range, i_cmd.rd_scan, r_idx < r_count, "scan past held entries")
    `FCMT_ASSERT_IMPL(a_no_overwrite, i_cmd.res_load, out_free, "pending result overwritten")
    `FCMT_ASSERT_NEXT(a_add_grows, i_cmd.wr_add, r_count != '0, "add left table empty")

endmodule

// ----- hdl/fixed_capacity_multiset_table_core.sv -----
// ----------------------------------------------------------------------------
// Fixed capacity multiset table core
// Unordered bag of up to CAPACITY values: add, remove first match, count, clear.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                   | tuser
//  s_axis  | in  | item_value[31:0]        | action[1:0]
//  m_axis  | out | success, match_count,   | -
//          |     | size_now, is_empty,     |
//          |     | is_full                 |
//
//  Add and clear go from accept through the execute state to the result; count
//  and a missed remove scan every held entry; a remove that hits stops at its
//  first match, then reads the last entry and writes it into the matched slot.
//  The single read port of the entry memory limits the scan to one entry per
//  cycle. One action is in flight at a time; the next word is accepted while a
//  result waits in the output register. Reset is synchronous, active low, and
//  empties the table at once.
// ----------------------------------------------------------------------------
module fixed_capacity_multiset_table_core import fcmt_pkg::*; #(
    parameter int CAPACITY   = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,   // [31:0] item_value
    input  logic [ACT_W-1:0]   s_axis_tuser,   // [1:0] action
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [OUT_W-1:0]   m_axis_tdata    // [0] success, [5:1] match_count,
                                               // [10:6] size_now, [11] is_empty,
                                               // [12] is_full, [15:13] zero
);

    t_action act;
    t_dp_cmd cmd;
    t_dp_sts sts;

    assign act = t_action'(s_axis_tuser);

    fcmt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_act     (act),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    fcmt_dp #(
        .CAPACITY   (CAPACITY),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_act     (act),
        .i_value   (s_axis_tdata),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_data  (m_axis_tdata)
    );

endmodule
